[hw/rtl/psc_pkg.sv]
// Shared definitions for the pot sample conditioner: default widths, register
// indexes, the sequencer state type and the quantizer result struct.
// No dependencies.
package psc_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF   = 12;

  // EMA weight is Q0.16 with one extra bit so that 1.0 and above fit.
  localparam int ALPHA_FRAC = 16;
  localparam int ALPHA_W    = ALPHA_FRAC + 1;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd16384;

  localparam int STEP_W    = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_STEPS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HYST      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH    = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_EMA,
    ST_SUM,
    ST_NF,
    ST_NH,
    ST_QUANT
  } psc_state_t;

  typedef struct packed {
    logic [STEP_W-1:0] last_step;
    logic [STEP_W-1:0] step_index;
  } psc_step_t;

endpackage

[hw/rtl/psc_if.sv]
// Valid/ready channel interfaces for the sample input and the result output.
// Depends on psc_pkg for default widths and the step field width.
interface psc_sample_if #(
  parameter int SAMPLE_BITS = psc_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] raw_sample;

  modport source (output valid, output raw_sample, input ready);
  modport sink (input valid, input raw_sample, output ready);
endinterface

interface psc_result_if #(
  parameter int SAMPLE_BITS = psc_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = psc_pkg::FRAC_BITS_DEF
);
  logic                                valid;
  logic                                ready;
  logic [SAMPLE_BITS+FRAC_BITS-1:0]    filtered_out;
  logic [psc_pkg::STEP_W-1:0]          step_index;
  logic                                changed;
  logic [SAMPLE_BITS-1:0]              stable_out;

  modport source (output valid, output filtered_out, output step_index,
                  output changed, output stable_out, input ready);
  modport sink (input valid, input filtered_out, input step_index,
                input changed, input stable_out, output ready);
endinterface

[hw/rtl/psc_mul.sv]
// Shared signed multiplier with a registered product, used for the EMA term
// and both quantizer scalings. No dependencies beyond its parameters.
module psc_mul #(
  parameter int OPU_W = 17,
  parameter int OPS_W = 25
) (
  input  logic                          clk,
  input  logic [OPU_W-1:0]              op_u,
  input  logic signed [OPS_W-1:0]       op_s,
  output logic signed [OPU_W+OPS_W:0]   prod_r
);

  logic signed [OPU_W+OPS_W:0] prod_c;

  assign prod_c = $signed({1'b0, op_u}) * op_s;

  always_ff @(posedge clk) begin
    prod_r <= prod_c;
  end

endmodule

[hw/rtl/psc_quant.sv]
// Hysteretic quantizer decision: candidate bin from n*f and the step update.
// Depends on psc_pkg for the step width and the result struct.
module psc_quant #(
  parameter int SAMPLE_BITS = psc_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = psc_pkg::FRAC_BITS_DEF
) (
  input  logic [psc_pkg::STEP_W+SAMPLE_BITS+FRAC_BITS-1:0] nf,
  input  logic [psc_pkg::STEP_W+SAMPLE_BITS+FRAC_BITS-1:0] nh,
  input  logic [psc_pkg::STEP_W-1:0]                       num_steps,
  input  logic [psc_pkg::STEP_W-1:0]                       last_step,
  output psc_pkg::psc_step_t                               step
);

  localparam int SW   = psc_pkg::STEP_W;
  localparam int NF_W = SW + SAMPLE_BITS + FRAC_BITS;
  localparam int X_W  = SW + SAMPLE_BITS;
  localparam logic [SAMPLE_BITS-1:0] SMAX = {SAMPLE_BITS{1'b1}};

  logic [X_W-1:0]         x;
  logic [SW-1:0]          q0;
  logic [SAMPLE_BITS:0]   rem;
  logic [SW:0]            qi;
  logic [SW-1:0]          nm1;
  logic [SW-1:0]          cand;
  logic [SW-1:0]          cand_p1;
  logic [X_W-1:0]         lo_m;
  logic [X_W-1:0]         hi_m;
  logic [NF_W-1:0]        lo_full;
  logic [NF_W-1:0]        hi_full;
  logic                   up_ok;
  logic                   dn_ok;
  logic [SW-1:0]          nxt;

  always_comb begin
    // Divide n*f by SMAX << FRAC_BITS: drop the fraction, then divide by
    // 2^S - 1 as x >> S plus a small correction from the remainder.
    x   = nf[NF_W-1:FRAC_BITS];
    q0  = x[X_W-1:SAMPLE_BITS];
    rem = {1'b0, x[SAMPLE_BITS-1:0]} + {{(SAMPLE_BITS+1-SW){1'b0}}, q0};
    if (rem >= {SMAX, 1'b0}) begin
      qi = {1'b0, q0} + 9'(2);
    end else if (rem >= {1'b0, SMAX}) begin
      qi = {1'b0, q0} + 9'(1);
    end else begin
      qi = {1'b0, q0};
    end
    nm1  = num_steps - SW'(1);
    cand = (qi > {1'b0, nm1}) ? nm1 : qi[SW-1:0];
    cand_p1 = cand + SW'(1);

    lo_m    = {cand, {SAMPLE_BITS{1'b0}}} - {{SAMPLE_BITS{1'b0}}, cand};
    hi_m    = {cand_p1, {SAMPLE_BITS{1'b0}}} - {{SAMPLE_BITS{1'b0}}, cand_p1};
    lo_full = {lo_m, {FRAC_BITS{1'b0}}};
    hi_full = {hi_m, {FRAC_BITS{1'b0}}};

    up_ok = {1'b0, nf} >= ({1'b0, lo_full} + {1'b0, nh});
    dn_ok = ({1'b0, nf} + {1'b0, nh}) <= {1'b0, hi_full};

    nxt = last_step;
    if (num_steps > SW'(1)) begin
      if (cand > last_step) begin
        if (up_ok) begin
          nxt = cand;
        end else if ((cand - SW'(1)) > last_step) begin
          nxt = cand - SW'(1);
        end
      end else if (cand < last_step) begin
        if (dn_ok) begin
          nxt = cand;
        end else if (cand_p1 < last_step) begin
          nxt = cand_p1;
        end
      end
    end

    step.last_step  = nxt;
    step.step_index = (num_steps > SW'(1)) ? nxt : '0;
  end

endmodule

[hw/rtl/pot_sample_conditioner.sv]
// Top level of the pot sample conditioner: registers, sequencer and datapath.
// Depends on psc_pkg, psc_if, psc_mul and psc_quant.

// Each sample is snapped at the ends of the range, qualified against the
// deadband, run through an EMA in unsigned Q(SAMPLE_BITS).(FRAC_BITS) and a
// hysteretic quantizer, and one result transaction comes out per sample. The
// result register is loaded as the sequencer leaves ST_QUANT, after ST_PREP,
// ST_EMA, ST_SUM, ST_NF and ST_NH (the first sample after reset skips the EMA
// states), because one 18 x (SAMPLE_BITS + FRAC_BITS + 1) multiplier is used
// in turn for the EMA term, n*f and n*hysteresis. The next sample can be
// accepted in the cycle after the result register is loaded, not before.
// in_chan.ready is high only while the sequencer is idle; a new sample is taken
// while the previous result still waits in the output register, and the
// sequencer holds its finished result until that register is free.
// Configuration must be written through cfg_we/cfg_index/cfg_data only while
// the block is idle, which only the user ensures; unknown indexes are ignored.
module pot_sample_conditioner #(
  parameter int SAMPLE_BITS = psc_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = psc_pkg::FRAC_BITS_DEF,
  localparam int FW    = SAMPLE_BITS + FRAC_BITS,
  localparam int CFG_W = (FW > psc_pkg::ALPHA_W) ? FW : psc_pkg::ALPHA_W
) (
  input  logic                          clk,
  input  logic                          rst_n,
  psc_sample_if.sink                    in_chan,
  psc_result_if.source                  out_chan,
  input  logic                          cfg_we,
  input  logic [psc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]              cfg_data
);

  localparam int SW     = psc_pkg::STEP_W;
  localparam int AW     = psc_pkg::ALPHA_W;
  localparam int AF     = psc_pkg::ALPHA_FRAC;
  localparam int OPS_W  = FW + 1;
  localparam int PROD_W = AW + OPS_W + 1;
  localparam int NF_W   = SW + FW;
  localparam int EV_W   = PROD_W + 1 - AF;
  localparam logic [SAMPLE_BITS-1:0] SMAX = {SAMPLE_BITS{1'b1}};
  localparam logic [FW-1:0] FULL = {SMAX, {FRAC_BITS{1'b0}}};

  psc_pkg::psc_state_t state_r;
  psc_pkg::psc_state_t state_nxt;

  // Configuration registers
  logic [SAMPLE_BITS-1:0] deadband_r;
  logic [AW-1:0]          alpha_r;
  logic [SW-1:0]          nsteps_r;
  logic [FW-1:0]          hyst_r;
  logic [FW-1:0]          thresh_r;

  // Filter state
  logic                   primed_r;
  logic [SAMPLE_BITS-1:0] stable_r;
  logic [FW-1:0]          filtered_r;
  logic [SW-1:0]          last_step_r;
  logic [FW-1:0]          last_rep_r;

  logic [SAMPLE_BITS-1:0] raw_r;
  logic [NF_W-1:0]        nf_r;

  logic                   out_valid_r;
  logic [FW-1:0]          out_filtered_r;
  logic [SW-1:0]          out_step_r;
  logic                   out_changed_r;
  logic [SAMPLE_BITS-1:0] out_stable_r;

  logic [SAMPLE_BITS-1:0] hi_edge;
  logic [SAMPLE_BITS-1:0] adj;
  logic [SAMPLE_BITS-1:0] move;
  logic signed [OPS_W-1:0] ema_diff;
  logic [AW-1:0]           op_u;
  logic signed [OPS_W-1:0] op_s;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W:0]  ema_sum;
  logic [EV_W-1:0]         ema_shr;
  logic [FW-1:0]           ema_val;
  logic [FW-1:0]           rep_diff;
  logic                    chg;
  logic                    commit;
  psc_pkg::psc_step_t      step;

  psc_mul #(
    .OPU_W (AW),
    .OPS_W (OPS_W)
  ) u_mul (
    .clk    (clk),
    .op_u   (op_u),
    .op_s   (op_s),
    .prod_r (prod_r)
  );

  psc_quant #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_quant (
    .nf        (nf_r),
    .nh        (prod_r[NF_W-1:0]),
    .num_steps (nsteps_r),
    .last_step (last_step_r),
    .step      (step)
  );

  // Snap and deadband qualification of the captured sample.
  always_comb begin
    hi_edge = (SMAX > deadband_r) ? (SMAX - deadband_r) : '0;
    adj     = raw_r;
    if (deadband_r != '0) begin
      if (raw_r <= deadband_r) begin
        adj = '0;
      end else if (raw_r >= hi_edge) begin
        adj = SMAX;
      end
    end
    move = (adj > stable_r) ? (adj - stable_r) : (stable_r - adj);
  end

  // EMA rewritten as alpha * (target - prev) + prev * 2^16, one product.
  always_comb begin
    ema_diff = $signed({1'b0, stable_r, {FRAC_BITS{1'b0}}}) - $signed({1'b0, filtered_r});
    ema_sum  = $signed({prod_r[PROD_W-1], prod_r})
             + $signed({{(PROD_W+1-FW-AF){1'b0}}, filtered_r, {AF{1'b0}}});
    ema_shr  = ema_sum[PROD_W:AF];
    if (ema_sum[PROD_W] || (ema_sum == '0)) begin
      ema_val = '0;
    end else if (ema_shr > {{(EV_W-FW){1'b0}}, FULL}) begin
      ema_val = FULL;
    end else begin
      ema_val = ema_shr[FW-1:0];
    end
  end

  always_comb begin
    case (state_r)
      psc_pkg::ST_EMA: begin
        op_u = alpha_r;
        op_s = ema_diff;
      end
      psc_pkg::ST_NF: begin
        op_u = {{(AW-SW){1'b0}}, nsteps_r};
        op_s = $signed({1'b0, filtered_r});
      end
      default: begin
        op_u = {{(AW-SW){1'b0}}, nsteps_r};
        op_s = $signed({1'b0, hyst_r});
      end
    endcase
  end

  always_comb begin
    rep_diff = (filtered_r > last_rep_r) ? (filtered_r - last_rep_r)
                                         : (last_rep_r - filtered_r);
    chg = (rep_diff >= thresh_r);
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    commit    = 1'b0;
    case (state_r)
      psc_pkg::ST_IDLE: begin
        if (in_chan.valid) begin
          state_nxt = psc_pkg::ST_PREP;
        end
      end
      psc_pkg::ST_PREP: begin
        state_nxt = primed_r ? psc_pkg::ST_EMA : psc_pkg::ST_NF;
      end
      psc_pkg::ST_EMA: begin
        state_nxt = psc_pkg::ST_SUM;
      end
      psc_pkg::ST_SUM: begin
        state_nxt = psc_pkg::ST_NF;
      end
      psc_pkg::ST_NF: begin
        state_nxt = psc_pkg::ST_NH;
      end
      psc_pkg::ST_NH: begin
        state_nxt = psc_pkg::ST_QUANT;
      end
      psc_pkg::ST_QUANT: begin
        if (!out_valid_r || out_chan.ready) begin
          commit    = 1'b1;
          state_nxt = psc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = psc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= psc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r  <= '0;
      alpha_r     <= psc_pkg::ALPHA_RESET;
      nsteps_r    <= '0;
      hyst_r      <= '0;
      thresh_r    <= '0;
      primed_r    <= 1'b0;
      stable_r    <= '0;
      filtered_r  <= '0;
      last_step_r <= '0;
      last_rep_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          psc_pkg::REG_DEADBAND:  deadband_r <= cfg_data[SAMPLE_BITS-1:0];
          psc_pkg::REG_ALPHA:     alpha_r    <= cfg_data[AW-1:0];
          psc_pkg::REG_NUM_STEPS: nsteps_r   <= cfg_data[SW-1:0];
          psc_pkg::REG_HYST:      hyst_r     <= cfg_data[FW-1:0];
          psc_pkg::REG_THRESH:    thresh_r   <= cfg_data[FW-1:0];
          default: ;
        endcase
      end

      if (state_r == psc_pkg::ST_PREP) begin
        if (!primed_r) begin
          // The first sample seeds the stable, filtered and last reported values and skips the EMA.
          stable_r   <= adj;
          filtered_r <= {adj, {FRAC_BITS{1'b0}}};
          last_rep_r <= {adj, {FRAC_BITS{1'b0}}};
          primed_r   <= 1'b1;
        end else if (move >= deadband_r) begin
          stable_r <= adj;
        end
      end

      if (state_r == psc_pkg::ST_SUM) begin
        filtered_r <= ema_val;
      end

      if (commit) begin
        last_step_r <= step.last_step;
        if (chg) begin
          last_rep_r <= filtered_r;
        end
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      raw_r <= in_chan.raw_sample;
    end
    if (state_r == psc_pkg::ST_NH) begin
      nf_r <= prod_r[NF_W-1:0];
    end
    if (commit) begin
      out_filtered_r <= filtered_r;
      out_step_r     <= step.step_index;
      out_changed_r  <= chg;
      out_stable_r   <= stable_r;
    end
  end

  assign in_chan.ready         = (state_r == psc_pkg::ST_IDLE);
  assign out_chan.valid        = out_valid_r;
  assign out_chan.filtered_out = out_filtered_r;
  assign out_chan.step_index   = out_step_r;
  assign out_chan.changed      = out_changed_r;
  assign out_chan.stable_out   = out_stable_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> (state_r == psc_pkg::ST_PREP))
    else $error("sequencer did not start after an input transaction");

  a_primed_past_prep: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r != psc_pkg::ST_IDLE) && (state_r != psc_pkg::ST_PREP)) |-> primed_r)
    else $error("arithmetic state reached before the filter was primed");

  a_commit_reports: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (out_valid_r && (!out_changed_r || (last_rep_r == out_filtered_r))))
    else $error("changed result does not match the last reported value");

  a_filtered_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == psc_pkg::ST_QUANT) |-> (filtered_r <= FULL))
    else $error("filtered value above full scale");
`endif

endmodule

[bench/tb.sv]
// Self-checking testbench for pot_sample_conditioner: a directed table, then random
// phases of samples with reconfiguration between them, each checked by a bit-accurate predictor.
// Depends on psc_pkg, the psc_sample_if and psc_result_if interfaces, and the block's RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDX_W = psc_pkg::CFG_IDX_W;

  localparam logic [IDX_W-1:0] REG_FIRST_SPARE = 3'd5;
  localparam logic [IDX_W-1:0] REG_LAST_SPARE  = 3'd7;

  localparam logic [11:0] SAMPLE_TOP  = 12'hFFF;
  localparam logic [23:0] FULL_Q      = 24'd16773120;
  localparam longint unsigned FULL_SCALE = 64'd16773120;
  localparam longint ALPHA_ONE = 64'd1 << psc_pkg::ALPHA_FRAC;
  localparam logic [23:0] ALPHA_MAX = 24'd131071;

  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 66;
  localparam int SETTLE_CYCLES   = 12;
  localparam int DRAIN_CYCLES    = 20;
  localparam int RX_HOLD_CYCLES  = 400;
  localparam int WATCHDOG_LIMIT  = 5000;

  typedef struct packed {
    logic [23:0] filtered;
    logic [7:0]  step;
    logic        changed;
    logic [11:0] stable;
  } psc_res_t;

  typedef struct {
    bit               is_reg;
    logic [IDX_W-1:0] idx;
    logic [23:0]      data;
    logic [11:0]      raw;
    bit               known;
    psc_res_t         want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [23:0] cfg_data;

  psc_sample_if in_chan();
  psc_result_if out_chan();

  pot_sample_conditioner u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5ns clk = ~clk;

  // Mirror of the block's registers and state.
  logic [11:0] db_cfg     = 12'd0;
  logic [16:0] alpha_cfg  = psc_pkg::ALPHA_RESET;
  logic [7:0]  steps_cfg  = 8'd0;
  logic [23:0] hyst_cfg   = 24'd0;
  logic [23:0] thresh_cfg = 24'd0;

  bit          pot_primed   = 1'b0;
  logic [11:0] pot_stable   = 12'd0;
  logic [23:0] pot_filt     = 24'd0;
  logic [7:0]  pot_step     = 8'd0;
  logic [23:0] pot_reported = 24'd0;

  psc_res_t pending_results[$];
  int mismatches = 0;
  int quiet_cycles = 0;
  bit rx_hold_req = 1'b0;
  bit tx_calm = 1'b0;
  int tx_mode_left = 0;
  int pot_pos = 2048;

  function automatic psc_res_t condition_sample(input logic [11:0] raw);
    logic [11:0] adj, hi_edge, delta;
    longint a, target, prev, sum;
    longint unsigned v, n, nf, nh, cand, diff;
    psc_res_t r;
    adj = raw;
    hi_edge = (db_cfg < SAMPLE_TOP) ? SAMPLE_TOP - db_cfg : 12'd0;
    if (db_cfg != 12'd0) begin
      if (adj <= db_cfg) adj = 12'd0;
      else if (adj >= hi_edge) adj = SAMPLE_TOP;
    end
    if (!pot_primed) begin
      pot_stable = adj;
      pot_filt = {adj, 12'd0};
      pot_reported = pot_filt;
      pot_primed = 1'b1;
    end else begin
      delta = (adj > pot_stable) ? adj - pot_stable : pot_stable - adj;
      if (delta >= db_cfg) pot_stable = adj;
      a = longint'(alpha_cfg);
      target = longint'({pot_stable, 12'd0});
      prev = longint'(pot_filt);
      // Alpha above one makes the old-value weight negative, so the sum is signed.
      sum = a * target + (ALPHA_ONE - a) * prev;
      if (sum <= 0) begin
        pot_filt = 24'd0;
      end else begin
        v = sum;
        v = v >> psc_pkg::ALPHA_FRAC;
        if (v > FULL_SCALE) v = FULL_SCALE;
        pot_filt = v[23:0];
      end
    end

    n = 64'(steps_cfg);
    if (n > 1) begin
      nf = n * 64'(pot_filt);
      nh = n * 64'(hyst_cfg);
      cand = nf / FULL_SCALE;
      if (cand > n - 1) cand = n - 1;
      if (cand > 64'(pot_step)) begin
        if (nf >= cand * FULL_SCALE + nh) pot_step = cand[7:0];
        else if (cand - 1 > 64'(pot_step)) pot_step = 8'(cand - 1);
      end else if (cand < 64'(pot_step)) begin
        if (nf + nh <= (cand + 1) * FULL_SCALE) pot_step = cand[7:0];
        else if (cand + 1 < 64'(pot_step)) pot_step = 8'(cand + 1);
      end
      r.step = pot_step;
    end else begin
      r.step = 8'd0;
    end

    diff = (pot_filt > pot_reported) ? 64'(pot_filt - pot_reported)
                                     : 64'(pot_reported - pot_filt);
    r.changed = 1'b0;
    if (diff >= 64'(thresh_cfg)) begin
      pot_reported = pot_filt;
      r.changed = 1'b1;
    end
    r.filtered = pot_filt;
    r.stable = pot_stable;
    return r;
  endfunction

  function automatic stim_row_t reg_row(input logic [IDX_W-1:0] idx,
                                        input logic [23:0] data);
    stim_row_t row;
    row = '{is_reg: 1'b1, idx: idx, data: data, raw: 12'd0, known: 1'b0, want: '0};
    return row;
  endfunction

  function automatic stim_row_t raw_row(input logic [11:0] raw);
    stim_row_t row;
    row = '{is_reg: 1'b0, idx: '0, data: 24'd0, raw: raw, known: 1'b0, want: '0};
    return row;
  endfunction

  function automatic stim_row_t known_row(input logic [11:0] raw, input logic [23:0] filt,
                                          input logic [7:0] step, input logic chg,
                                          input logic [11:0] stab);
    stim_row_t row;
    row = '{is_reg: 1'b0, idx: '0, data: 24'd0, raw: raw, known: 1'b1,
            want: '{filtered: filt, step: step, changed: chg, stable: stab}};
    return row;
  endfunction

  // The prediction is taken at the edge that accepts the sample, so results stay in order.
  task automatic send_sample(input logic [11:0] raw, input bit known, input psc_res_t given);
    psc_res_t model_res;
    in_chan.valid <= 1'b1;
    in_chan.raw_sample <= raw;
    do @(posedge clk); while (!in_chan.ready);
    model_res = condition_sample(raw);
    pending_results.push_back(known ? given : model_res);
  endtask

  task automatic sender_gap();
    int g, r;
    g = 0;
    if (tx_mode_left == 0) begin
      tx_mode_left = $urandom_range(30, 120);
      tx_calm = ($urandom_range(0, 3) == 0);
    end
    tx_mode_left--;
    if (!tx_calm) begin
      r = $urandom_range(0, 99);
      if (r < 55) g = 0;
      else if (r < 85) g = $urandom_range(1, 3);
      else if (r < 97) g = $urandom_range(4, 10);
      else g = $urandom_range(20, 60);
    end
    if (g != 0) begin
      in_chan.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Registers may only change while no sample is in flight.
  task automatic settle_block();
    in_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [23:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      psc_pkg::REG_DEADBAND:  db_cfg = data[11:0];
      psc_pkg::REG_ALPHA:     alpha_cfg = data[16:0];
      psc_pkg::REG_NUM_STEPS: steps_cfg = data[7:0];
      psc_pkg::REG_HYST:      hyst_cfg = data;
      psc_pkg::REG_THRESH:    thresh_cfg = data;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [11:0] next_pot_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      pot_pos = pot_pos + int'($urandom_range(0, 60)) - 30;
      if (pot_pos < 0) pot_pos = 0;
      if (pot_pos > 4095) pot_pos = 4095;
    end else if (r < 80) begin
      pot_pos = int'($urandom_range(0, 4095));
    end else if (r < 90) begin
      pot_pos = ($urandom_range(0, 1) == 0) ? int'($urandom_range(0, 8))
                                             : 4095 - int'($urandom_range(0, 8));
    end
    return 12'(pot_pos);
  endfunction

  task automatic check_field(input string name, input logic [23:0] want, input logic [23:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    psc_res_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result: expected none, actual filtered %0d step %0d",
                 $time, out_chan.filtered_out, out_chan.step_index);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("filtered_out", want.filtered, out_chan.filtered_out);
        check_field("step_index", 24'(want.step), 24'(out_chan.step_index));
        check_field("changed", 24'(want.changed), 24'(out_chan.changed));
        check_field("stable_out", 24'(want.stable), 24'(out_chan.stable_out));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_chan.valid && in_chan.ready) ||
        (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t ns: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : result_sink
    int stall_left, mode_left, r;
    bit calm;
    stall_left = 0;
    mode_left = 0;
    calm = 1'b0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        // Long hold so the block fills up and back-pressures its input.
        out_chan.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
        out_chan.ready <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(40, 200);
          calm = ($urandom_range(0, 3) == 0);
        end
        mode_left--;
        if (stall_left > 0) begin
          stall_left--;
          out_chan.ready <= 1'b0;
        end else begin
          out_chan.ready <= 1'b1;
          if (!calm && $urandom_range(0, 99) < 25) begin
            r = $urandom_range(0, 99);
            if (r < 75) stall_left = $urandom_range(1, 3);
            else if (r < 95) stall_left = $urandom_range(4, 12);
            else stall_left = $urandom_range(30, 80);
          end
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t plan[$];
    stim_row_t row;
    logic [23:0] val;
    rst_n <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.raw_sample <= 12'd0;
    cfg_we <= 1'b0;
    cfg_index <= psc_pkg::REG_DEADBAND;
    cfg_data <= 24'd0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // First sample primes everything; with reset settings the rest follow simply.
    plan.push_back(known_row(12'd0, 24'd0, 8'd0, 1'b1, 12'd0));
    plan.push_back(known_row(SAMPLE_TOP, 24'd4193280, 8'd0, 1'b1, SAMPLE_TOP));
    plan.push_back(reg_row(psc_pkg::REG_ALPHA, 24'd65536));
    plan.push_back(known_row(SAMPLE_TOP, FULL_Q, 8'd0, 1'b1, SAMPLE_TOP));
    plan.push_back(reg_row(psc_pkg::REG_NUM_STEPS, 24'd255));
    plan.push_back(known_row(SAMPLE_TOP, FULL_Q, 8'd254, 1'b1, SAMPLE_TOP));
    plan.push_back(known_row(12'd0, 24'd0, 8'd0, 1'b1, 12'd0));
    // Alpha above one overshoots and hits the clamp at both ends.
    plan.push_back(reg_row(psc_pkg::REG_ALPHA, ALPHA_MAX));
    plan.push_back(known_row(SAMPLE_TOP, FULL_Q, 8'd254, 1'b1, SAMPLE_TOP));
    plan.push_back(known_row(12'd0, 24'd0, 8'd0, 1'b1, 12'd0));
    plan.push_back(reg_row(psc_pkg::REG_ALPHA, 24'd0));
    plan.push_back(known_row(SAMPLE_TOP, 24'd0, 8'd0, 1'b1, SAMPLE_TOP));
    // Deadband snapping at both ends and the minimum move of the stable sample.
    plan.push_back(reg_row(psc_pkg::REG_ALPHA, 24'd65536));
    plan.push_back(reg_row(psc_pkg::REG_DEADBAND, 24'd100));
    plan.push_back(known_row(12'd50, 24'd0, 8'd0, 1'b1, 12'd0));
    plan.push_back(known_row(12'd4000, FULL_Q, 8'd254, 1'b1, SAMPLE_TOP));
    plan.push_back(known_row(12'd3996, FULL_Q, 8'd254, 1'b1, SAMPLE_TOP));
    plan.push_back(raw_row(12'd2000));
    plan.push_back(raw_row(12'd2050));
    plan.push_back(reg_row(psc_pkg::REG_DEADBAND, 24'd4095));
    plan.push_back(raw_row(12'd3000));
    // Fewer bins than the current step: the step has to walk back into range.
    plan.push_back(reg_row(psc_pkg::REG_DEADBAND, 24'd0));
    plan.push_back(reg_row(psc_pkg::REG_NUM_STEPS, 24'd8));
    plan.push_back(raw_row(12'd2000));
    plan.push_back(reg_row(psc_pkg::REG_NUM_STEPS, 24'd1));
    plan.push_back(raw_row(SAMPLE_TOP));
    plan.push_back(reg_row(psc_pkg::REG_NUM_STEPS, 24'd4));
    plan.push_back(reg_row(psc_pkg::REG_HYST, 24'd2000000));
    plan.push_back(reg_row(psc_pkg::REG_THRESH, 24'd1000000));
    plan.push_back(reg_row(psc_pkg::REG_ALPHA, 24'd30000));
    plan.push_back(raw_row(SAMPLE_TOP));
    plan.push_back(raw_row(SAMPLE_TOP));
    plan.push_back(raw_row(12'd2600));
    plan.push_back(raw_row(12'd1000));
    plan.push_back(raw_row(12'd0));
    plan.push_back(reg_row(psc_pkg::REG_HYST, FULL_Q));
    plan.push_back(reg_row(psc_pkg::REG_THRESH, FULL_Q));
    plan.push_back(raw_row(SAMPLE_TOP));
    plan.push_back(raw_row(12'd0));
    plan.push_back(reg_row(REG_LAST_SPARE, 24'hFFFFFF));
    plan.push_back(raw_row(12'd1234));

    foreach (plan[i]) begin
      row = plan[i];
      if (row.is_reg) begin
        settle_block();
        write_reg(row.idx, row.data);
      end else begin
        send_sample(row.raw, row.known, row.want);
        sender_gap();
      end
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      settle_block();
      case ($urandom_range(0, 7))
        0, 1:    val = 24'd0;
        2, 3, 4: val = 24'($urandom_range(1, 40));
        5:       val = 24'($urandom_range(41, 4094));
        6:       val = 24'd4095;
        default: val = 24'd1;
      endcase
      write_reg(psc_pkg::REG_DEADBAND, val);
      case ($urandom_range(0, 7))
        0:       val = 24'd65536;
        1:       val = 24'd0;
        2:       val = ALPHA_MAX;
        3:       val = 24'($urandom_range(65537, 131071));
        4:       val = 24'($urandom_range(256, 16384));
        default: val = 24'($urandom_range(1, 65535));
      endcase
      write_reg(psc_pkg::REG_ALPHA, val);
      case ($urandom_range(0, 7))
        0:       val = 24'd0;
        1:       val = 24'd1;
        2:       val = 24'd2;
        3:       val = 24'd255;
        4:       val = 24'($urandom_range(0, 255));
        default: val = 24'($urandom_range(3, 32));
      endcase
      write_reg(psc_pkg::REG_NUM_STEPS, val);
      case ($urandom_range(0, 5))
        0:       val = 24'd0;
        1:       val = FULL_Q;
        2:       val = 24'($urandom_range(0, 16773120));
        default: val = 24'($urandom_range(0, 1 << 20));
      endcase
      write_reg(psc_pkg::REG_HYST, val);
      case ($urandom_range(0, 5))
        0:       val = 24'd0;
        1:       val = FULL_Q;
        2:       val = 24'($urandom_range(0, 16773120));
        default: val = 24'($urandom_range(0, 1 << 18));
      endcase
      write_reg(psc_pkg::REG_THRESH, val);
      if ($urandom_range(0, 2) == 0)
        write_reg(IDX_W'($urandom_range(REG_FIRST_SPARE, REG_LAST_SPARE)), 24'($urandom));

      if (phase == 1) begin
        // Keep offering samples back to back while the receiver holds off.
        rx_hold_req = 1'b1;
        tx_calm = 1'b1;
        tx_mode_left = 30;
      end
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        send_sample(next_pot_sample(), 1'b0, '0);
        sender_gap();
      end
    end

    in_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/psc_pkg.sv
hw/rtl/psc_if.sv
hw/rtl/psc_mul.sv
hw/rtl/psc_quant.sv
hw/rtl/pot_sample_conditioner.sv
bench/tb.sv
